// ===== src/bsds_pkg.sv =====
// ----------------------------------------------------------------------------
// bsds_pkg
// Shared types and constants of the bump and search drive selector.
// ----------------------------------------------------------------------------
package bsds_pkg;

  typedef enum logic [2:0] {
    ACT_FORWARD      = 3'd0,
    ACT_PUCK         = 3'd1,
    ACT_BOTH         = 3'd2,
    ACT_LEFT         = 3'd3,
    ACT_RIGHT        = 3'd4,
    ACT_LIGHT        = 3'd5,
    ACT_SEARCH_LEFT  = 3'd6,
    ACT_SEARCH_RIGHT = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    CFG_BACKOFF = 2'd0,
    CFG_SEARCH  = 2'd1,
    CFG_FORWARD = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_index_t;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned DRIVE_W = 8;

  localparam logic [TICK_W-1:0] BACKOFF_RESET = 16'd500;
  localparam logic [TICK_W-1:0] SEARCH_RESET  = 16'd2300;
  localparam logic [TICK_W-1:0] FORWARD_RESET = 16'd1500;

  localparam logic signed [DRIVE_W-1:0] DRV_STOP     = 8'sd0;
  localparam logic signed [DRIVE_W-1:0] DRV_REV_FAST = -8'sd120;
  localparam logic signed [DRIVE_W-1:0] DRV_REV_SLOW = -8'sd100;
  localparam logic signed [DRIVE_W-1:0] DRV_TURN_REV = -8'sd95;
  localparam logic signed [DRIVE_W-1:0] DRV_TURN_FWD = 8'sd95;
  localparam logic signed [DRIVE_W-1:0] DRV_FWD      = 8'sd100;

endpackage

// ===== src/bump_and_search_drive_selector_core.sv =====
// ----------------------------------------------------------------------------
// bump_and_search_drive_selector_core
// Priority drive selector with a restartable countdown, one result per tick.
// ----------------------------------------------------------------------------
// Each input item is one sensor tick and yields exactly one result item. The
// whole decision is one level of logic between the action/timer registers and
// the output register, so the block takes one item per clock cycle and
// registers each result when its tick is accepted; s_tready stays high while
// the output register is empty or being drained in the same cycle, so
// throughput is bounded only by how fast the sink takes results.
module bump_and_search_drive_selector_core
  import bsds_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // puck_touch, light_seen, left_bump, right_bump
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata,   // left_drive[7:0], right_drive[7:0], action_code[2:0]
  output logic                m_tuser,   // publish
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [TICK_W-1:0]   cfg_data
);

  logic [TICK_W-1:0] backoff_ticks;
  logic [TICK_W-1:0] search_ticks;
  logic [TICK_W-1:0] forward_ticks;

  action_t           action, action_next;
  logic              time_up, time_up_next;
  logic [TICK_W-1:0] countdown, countdown_next;
  logic              timer_armed, timer_armed_next;

  logic                      pub;
  logic signed [DRIVE_W-1:0] drv_l, drv_r;

  logic puck, light, lb, rb;
  logic accept;

  assign puck  = s_tdata[0];
  assign light = s_tdata[1];
  assign lb    = s_tdata[2];
  assign rb    = s_tdata[3];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    logic              tu;
    logic [TICK_W-1:0] cd;
    logic              armed;
    logic              load;
    logic [TICK_W-1:0] load_val;

    tu       = time_up;
    cd       = countdown;
    armed    = timer_armed;
    load     = 1'b0;
    load_val = backoff_ticks;
    pub      = 1'b0;
    drv_l    = DRV_STOP;
    drv_r    = DRV_STOP;
    action_next = action;

    // timer runs before the priority rule
    if (armed) begin
      if (cd <= 16'd1) begin
        cd    = '0;
        armed = 1'b0;
        tu    = 1'b1;
      end else begin
        cd = cd - 16'd1;
      end
    end

    if (puck) begin
      if (action != ACT_PUCK) begin
        pub = 1'b1;
        action_next = ACT_PUCK;
        tu = 1'b1;
      end
    end else if (lb && rb) begin
      if (action != ACT_BOTH) begin
        pub = 1'b1;
        drv_l = DRV_REV_FAST;
        drv_r = DRV_REV_FAST;
        action_next = ACT_BOTH;
        tu = 1'b0;
        load = 1'b1;
      end
    end else if (lb) begin
      if (action != ACT_LEFT) begin
        pub = 1'b1;
        drv_l = DRV_REV_SLOW;
        drv_r = DRV_REV_FAST;
        action_next = ACT_LEFT;
        tu = 1'b0;
        load = 1'b1;
      end
    end else if (rb) begin
      if (action != ACT_RIGHT) begin
        pub = 1'b1;
        drv_l = DRV_REV_FAST;
        drv_r = DRV_REV_SLOW;
        action_next = ACT_RIGHT;
        tu = 1'b0;
        load = 1'b1;
      end
    end else if (light) begin
      if (action != ACT_LIGHT) begin
        pub = 1'b1;
        drv_l = DRV_FWD;
        drv_r = DRV_FWD;
        action_next = ACT_LIGHT;
        tu = 1'b1;
      end
    end else if (tu) begin
      pub  = 1'b1;
      tu   = 1'b0;
      load = 1'b1;
      case (action)
        ACT_FORWARD, ACT_PUCK, ACT_RIGHT: begin
          drv_l = DRV_TURN_REV;
          drv_r = DRV_TURN_FWD;
          action_next = ACT_SEARCH_LEFT;
          load_val = search_ticks;
        end
        ACT_LEFT, ACT_LIGHT, ACT_BOTH: begin
          drv_l = DRV_FWD;
          drv_r = DRV_REV_SLOW;
          action_next = ACT_SEARCH_RIGHT;
          load_val = search_ticks;
        end
        default: begin
          drv_l = DRV_FWD;
          drv_r = DRV_FWD;
          action_next = ACT_FORWARD;
          load_val = forward_ticks;
        end
      endcase
    end

    if (load) begin
      cd    = load_val;
      armed = 1'b1;
    end

    time_up_next     = tu;
    countdown_next   = cd;
    timer_armed_next = armed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      backoff_ticks <= BACKOFF_RESET;
      search_ticks  <= SEARCH_RESET;
      forward_ticks <= FORWARD_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_BACKOFF: backoff_ticks <= cfg_data;
        CFG_SEARCH:  search_ticks  <= cfg_data;
        CFG_FORWARD: forward_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      action      <= ACT_FORWARD;
      time_up     <= 1'b1;
      countdown   <= '0;
      timer_armed <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        action      <= action_next;
        time_up     <= time_up_next;
        countdown   <= countdown_next;
        timer_armed <= timer_armed_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {5'd0, action_next, drv_r, drv_l};
      m_tuser <= pub;
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the bump and search drive selector core: sensor ticks go in
// on the input stream, a drive command predictor computes each expected
// result, and every result item on the output stream is compared with it.
// ----------------------------------------------------------------------------
module tb;
  import bsds_pkg::*;

  typedef struct {
    bit                        publish;
    logic signed [DRIVE_W-1:0] left_drv;
    logic signed [DRIVE_W-1:0] right_drv;
    action_t                   act;
  } drive_cmd_t;

  // Predicts the drive command of each tick and holds the ones not yet seen.
  class drive_cmd_board;
    logic [TICK_W-1:0] backoff_len;
    logic [TICK_W-1:0] search_len;
    logic [TICK_W-1:0] forward_len;
    action_t           act;
    bit                time_up;
    logic [TICK_W-1:0] countdown;
    bit                armed;
    drive_cmd_t        pending_cmds[$];
    int                errors;

    function new();
      backoff_len = BACKOFF_RESET;
      search_len  = SEARCH_RESET;
      forward_len = FORWARD_RESET;
      act         = ACT_FORWARD;
      time_up     = 1'b1;
      countdown   = '0;
      armed       = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [TICK_W-1:0] val);
      case (idx)
        CFG_BACKOFF: backoff_len = val;
        CFG_SEARCH:  search_len  = val;
        CFG_FORWARD: forward_len = val;
        default: ;
      endcase
    endfunction

    function void arm(logic [TICK_W-1:0] len);
      countdown = len;
      armed     = 1'b1;
    endfunction

    // sensors: {right_bump, left_bump, light_seen, puck_touch}
    function void note_tick(logic [3:0] sensors);
      drive_cmd_t cmd;
      action_t    nxt;
      cmd.publish   = 1'b0;
      cmd.left_drv  = DRV_STOP;
      cmd.right_drv = DRV_STOP;
      nxt = act;
      if (armed) begin
        if (countdown <= 1) begin
          countdown = '0;
          armed     = 1'b0;
          time_up   = 1'b1;
        end else begin
          countdown = countdown - 1'b1;
        end
      end
      if (sensors[0]) begin
        if (act != ACT_PUCK) begin
          cmd.publish = 1'b1; nxt = ACT_PUCK; time_up = 1'b1;
        end
      end else if (sensors[2] && sensors[3]) begin
        if (act != ACT_BOTH) begin
          cmd.publish = 1'b1; nxt = ACT_BOTH; time_up = 1'b0;
          cmd.left_drv = DRV_REV_FAST; cmd.right_drv = DRV_REV_FAST;
          arm(backoff_len);
        end
      end else if (sensors[2]) begin
        if (act != ACT_LEFT) begin
          cmd.publish = 1'b1; nxt = ACT_LEFT; time_up = 1'b0;
          cmd.left_drv = DRV_REV_SLOW; cmd.right_drv = DRV_REV_FAST;
          arm(backoff_len);
        end
      end else if (sensors[3]) begin
        if (act != ACT_RIGHT) begin
          cmd.publish = 1'b1; nxt = ACT_RIGHT; time_up = 1'b0;
          cmd.left_drv = DRV_REV_FAST; cmd.right_drv = DRV_REV_SLOW;
          arm(backoff_len);
        end
      end else if (sensors[1]) begin
        if (act != ACT_LIGHT) begin
          cmd.publish = 1'b1; nxt = ACT_LIGHT; time_up = 1'b1;
          cmd.left_drv = DRV_FWD; cmd.right_drv = DRV_FWD;
        end
      end else if (time_up) begin
        cmd.publish = 1'b1;
        time_up = 1'b0;
        case (act)
          ACT_FORWARD, ACT_PUCK, ACT_RIGHT: begin
            nxt = ACT_SEARCH_LEFT;
            cmd.left_drv = DRV_TURN_REV; cmd.right_drv = DRV_TURN_FWD;
            arm(search_len);
          end
          ACT_LEFT, ACT_LIGHT, ACT_BOTH: begin
            nxt = ACT_SEARCH_RIGHT;
            cmd.left_drv = DRV_FWD; cmd.right_drv = -DRV_FWD;
            arm(search_len);
          end
          default: begin
            nxt = ACT_FORWARD;
            cmd.left_drv = DRV_FWD; cmd.right_drv = DRV_FWD;
            arm(forward_len);
          end
        endcase
      end
      act     = nxt;
      cmd.act = nxt;
      pending_cmds.push_back(cmd);
    endfunction

    function void check_cmd(logic [23:0] data, logic pub);
      drive_cmd_t exp_cmd;
      if (pending_cmds.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result item: tdata %h tuser %b", data, pub);
        return;
      end
      exp_cmd = pending_cmds.pop_front();
      if (pub !== exp_cmd.publish || data[7:0] !== exp_cmd.left_drv ||
          data[15:8] !== exp_cmd.right_drv || data[18:16] !== exp_cmd.act) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: publish %b/%b left %0d/%0d right %0d/%0d action %0d/%0d",
                   exp_cmd.publish, pub, exp_cmd.left_drv, $signed(data[7:0]),
                   exp_cmd.right_drv, $signed(data[15:8]), exp_cmd.act, data[18:16]);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [23:0]       m_tdata;
  logic              m_tuser;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = CFG_BACKOFF;
  logic [TICK_W-1:0] cfg_data = '0;

  drive_cmd_board board = new();
  int send_idle = 35;
  int recv_idle = 51;
  int recv_hold = 0;

  bump_and_search_drive_selector_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // sink side: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      recv_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_cmd(m_tdata, m_tuser);
  end

  task automatic send_tick(input logic [3:0] sensors);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, sensors};
    do @(posedge clk); while (!s_tready);
    board.note_tick(sensors);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [TICK_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending_cmds.size() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Runs of held sensor patterns, mostly quiet so the timer gets to expire,
  // with single-tick glitches mixed in.
  task automatic random_ticks(input int n, input int hold_at);
    logic [3:0] pattern;
    logic [3:0] sensors;
    int run_len;
    int sent;
    sent = 0;
    while (sent < n) begin
      run_len = $urandom_range(1, 12);
      pattern = ($urandom_range(0, 99) < 55) ? 4'b0000 : 4'($urandom_range(0, 15));
      for (int k = 0; k < run_len && sent < n; k++) begin
        sensors = pattern;
        if ($urandom_range(0, 99) < 10) sensors[2'($urandom_range(0, 3))] ^= 1'b1;
        if (sent == hold_at) recv_hold = 300;
        send_tick(sensors);
        sent++;
      end
    end
  endtask

  logic [3:0] directed_a[] = '{4'b0000, 4'b0001, 4'b0001, 4'b1111, 4'b1100, 4'b1100,
                               4'b0100, 4'b1000, 4'b0010, 4'b0010, 4'b0000};
  // short timers: zero-length backoff, expiry into search and forward, restart
  logic [3:0] directed_b[] = '{4'b0100, 4'b0100, 4'b0000, 4'b0000, 4'b0000, 4'b0000,
                               4'b0000, 4'b1000, 4'b0010, 4'b0000, 4'b0001, 4'b0000,
                               4'b1010, 4'b0110};

  logic [TICK_W-1:0] phase_cfg[6][3] = '{
    '{16'd3,     16'd5,     16'd4},
    '{16'd0,     16'd0,     16'd0},
    '{16'hFFFF,  16'hFFFF,  16'hFFFF},
    '{16'd1,     16'd12,    16'd7},
    '{16'd20,    16'd2,     16'd1},
    '{16'd9,     16'd30,    16'd15}
  };

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_a[i]) send_tick(directed_a[i]);
    drain();
    write_reg(CFG_BACKOFF, 16'd0);
    write_reg(CFG_SEARCH, 16'd1);
    write_reg(CFG_FORWARD, 16'd2);
    write_reg(CFG_UNUSED, 16'hFFFF);
    foreach (directed_b[i]) send_tick(directed_b[i]);
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle = 51;
        recv_idle = 35;
      end else if (p == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_reg(CFG_BACKOFF, phase_cfg[p][0]);
      write_reg(CFG_SEARCH, phase_cfg[p][1]);
      write_reg(CFG_FORWARD, phase_cfg[p][2]);
      random_ticks(185, (p == 0 || p == 4) ? 40 : -1);
      drain();
    end

    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending_cmds.size() == 0) begin
      $display("bump_and_search_drive_selector_core test passed");
    end else begin
      $display("bump_and_search_drive_selector_core test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("bump_and_search_drive_selector_core test failed");
    $finish;
  end

endmodule
